// ===== rtl/core/cia_pkg.sv =====
// Package for the CIA timer/TOD slice: request codes, register addresses, BCD helpers.
// No dependencies.
`timescale 1ns / 1ps
package cia_pkg;
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;
    localparam logic [1:0] REQ_MAINS = 2'd3;

    localparam logic [3:0] ADDR_SER   = 4'h0;
    localparam logic [3:0] ADDR_PB    = 4'h1;
    localparam logic [3:0] ADDR_TALO  = 4'h4;
    localparam logic [3:0] ADDR_TAHI  = 4'h5;
    localparam logic [3:0] ADDR_TBLO  = 4'h6;
    localparam logic [3:0] ADDR_TBHI  = 4'h7;
    localparam logic [3:0] ADDR_TOD10 = 4'h8;
    localparam logic [3:0] ADDR_TODS  = 4'h9;
    localparam logic [3:0] ADDR_TODM  = 4'ha;
    localparam logic [3:0] ADDR_TODH  = 4'hb;
    localparam logic [3:0] ADDR_ICR   = 4'hd;
    localparam logic [3:0] ADDR_CRA   = 4'he;
    localparam logic [3:0] ADDR_CRB   = 4'hf;

    localparam logic [7:0] INT_TA    = 8'h01;
    localparam logic [7:0] INT_TB    = 8'h02;
    localparam logic [7:0] INT_ALARM = 8'h04;
    localparam logic [7:0] INT_REQ   = 8'h80;

    // BCD byte -> binary, +1, mod 10 -> BCD; the tens digit is a multiple of ten
    // and only feeds the carry
    function automatic logic [7:0] bcd_inc_tenths(input logic [7:0] v, output logic carry);
        logic [4:0] u;
        u = {1'b0, v[3:0]} + 5'd1;
        carry = (v[7:4] != 4'd0) || (u >= 5'd10);
        if (u >= 5'd10) u = u - 5'd10;
        return {4'd0, u[3:0]};
    endfunction

    // BCD byte -> binary (1..166 after +1), mod 60 by compare/subtract -> BCD
    function automatic logic [7:0] bcd_inc_sixty(input logic [7:0] v, output logic carry);
        logic [7:0] t;
        logic [7:0] r;
        logic [7:0] u;
        logic [3:0] tens;
        t = ({4'd0, v[7:4]} << 3) + ({4'd0, v[7:4]} << 1) + {4'd0, v[3:0]} + 8'd1;
        carry = (t >= 8'd60);
        if (t >= 8'd120) r = t - 8'd120;
        else if (t >= 8'd60) r = t - 8'd60;
        else r = t;
        if (r >= 8'd50) begin
            tens = 4'd5; u = r - 8'd50;
        end else if (r >= 8'd40) begin
            tens = 4'd4; u = r - 8'd40;
        end else if (r >= 8'd30) begin
            tens = 4'd3; u = r - 8'd30;
        end else if (r >= 8'd20) begin
            tens = 4'd2; u = r - 8'd20;
        end else if (r >= 8'd10) begin
            tens = 4'd1; u = r - 8'd10;
        end else begin
            tens = 4'd0; u = r;
        end
        return {tens, u[3:0]};
    endfunction
endpackage

// ===== rtl/core/cia_if.sv =====
// Valid/ready channel interface carrying a payload of type T.
// Depends on nothing.
`timescale 1ns / 1ps
interface cia_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/cia_timers_tod_interrupts_top.sv =====
// CIA slice: two timers, BCD time-of-day with alarm, interrupt control.
// The result register is loaded by the same clock edge that accepts a transaction.
// Throughput: one transaction per cycle while the output is taken; all work is one combinational pass on the state.
// Output register with ready-gated update; input ready while output empty or taken.
// Reset: synchronous active low, all state to power-on values.
`timescale 1ns / 1ps
module cia_timers_tod_interrupts_top
    import cia_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    cia_if.sink    i_req,
    cia_if.source  o_rsp
);
    logic [15:0] r_ta, r_tal, r_tb, r_tbl, n_ta, n_tal, n_tb, n_tbl;
    logic [7:0]  r_cra, r_crb, n_cra, n_crb, r_ist, n_ist, r_rot, n_rot;
    logic [4:0]  r_imsk, n_imsk;
    logic [7:0]  r_sh [16];
    logic [7:0]  r_tod [4], n_tod [4], r_alm [4], n_alm [4], r_hold [4], n_hold [4];
    logic        r_held, n_held, r_halt, n_halt;
    logic [2:0]  r_div, n_div;
    logic        r_ov;
    logic [7:0]  r_rd, n_rd;
    logic        r_irq;
    logic        acc;
    logic [1:0]  req;
    logic [3:0]  addr;
    logic [7:0]  wd, d;
    logic        a_under, tick_b, c0, c1, c2, alarm_eq;
    logic [2:0]  div_p;
    logic [4:0]  h;
    logic [7:0]  hpm;

    assign req  = i_req.data.req_type;
    assign addr = i_req.data.addr;
    assign wd   = i_req.data.write_data;
    assign i_req.ready = !r_ov || o_rsp.ready;
    assign acc  = i_req.valid && i_req.ready;
    assign o_rsp.valid = r_ov;
    assign o_rsp.data.read_data = r_rd;
    assign o_rsp.data.irq = r_irq;

    always_comb begin
        n_ta = r_ta; n_tal = r_tal; n_tb = r_tb; n_tbl = r_tbl;
        n_cra = r_cra; n_crb = r_crb; n_ist = r_ist; n_rot = r_rot; n_imsk = r_imsk;
        n_tod = r_tod; n_alm = r_alm; n_hold = r_hold;
        n_held = r_held; n_halt = r_halt; n_div = r_div; n_rd = 8'h00;
        a_under = 1'b0; tick_b = 1'b0; d = wd;
        c0 = 1'b0; c1 = 1'b0; c2 = 1'b0; div_p = 3'd0; h = 5'd0; hpm = 8'd0;
        alarm_eq = 1'b0;
        case (req)
            REQ_TICK: begin
                if ((r_cra & 8'h21) == 8'h01) begin
                    if (r_ta != 16'd0) n_ta = r_ta - 16'd1;
                    else begin
                        n_ta = r_tal; a_under = 1'b1;
                        if (r_cra[3]) n_cra[0] = 1'b0;
                        n_ist = n_ist | INT_TA;
                    end
                end
                tick_b = ((r_crb & 8'h61) == 8'h01) ||
                         ((((r_crb & 8'h61) == 8'h41) || ((r_crb & 8'h61) == 8'h61)) && a_under);
                if (tick_b) begin
                    if (r_tb != 16'd0) n_tb = r_tb - 16'd1;
                    else begin
                        n_tb = r_tbl;
                        if (r_crb[3]) n_crb[0] = 1'b0;
                        n_ist = n_ist | INT_TB;
                    end
                end
                if ((n_ist[4:0] & r_imsk) != 5'd0) n_ist = n_ist | INT_REQ;
            end
            REQ_READ: begin
                case (addr)
                    ADDR_SER: begin
                        n_rot = {r_rot[6:0], r_rot[7]};
                        n_rd = r_rot[6] ? 8'hff : 8'h3f;
                    end
                    ADDR_PB:   n_rd = 8'hff;
                    ADDR_TALO: n_rd = r_ta[7:0];
                    ADDR_TAHI: n_rd = r_ta[15:8];
                    ADDR_TBLO: n_rd = r_tb[7:0];
                    ADDR_TBHI: n_rd = r_tb[15:8];
                    ADDR_TOD10, ADDR_TODS, ADDR_TODM, ADDR_TODH: begin
                        if (!r_held) n_hold = r_tod;
                        if (addr == ADDR_TOD10) n_held = 1'b0;
                        if (addr == ADDR_TODH) n_held = 1'b1;
                        n_rd = n_hold[addr[1:0]];
                    end
                    ADDR_ICR: begin n_rd = r_ist; n_ist = 8'h00; end
                    ADDR_CRA: n_rd = r_cra;
                    ADDR_CRB: n_rd = r_crb;
                    default:  n_rd = r_sh[addr];
                endcase
            end
            REQ_WRITE: begin
                case (addr)
                    ADDR_TALO: n_tal = {r_tal[15:8], wd};
                    ADDR_TAHI: begin
                        n_tal = {wd, r_tal[7:0]};
                        if (!r_cra[0]) n_ta = n_tal;
                    end
                    ADDR_TBLO: n_tbl = {r_tbl[15:8], wd};
                    ADDR_TBHI: begin
                        n_tbl = {wd, r_tbl[7:0]};
                        if (!r_crb[0]) n_tb = n_tbl;
                    end
                    ADDR_TOD10, ADDR_TODS, ADDR_TODM, ADDR_TODH: begin
                        if (addr == ADDR_TODH) begin
                            d = wd & 8'h9f;
                            if (d[4:0] == 5'h12 && !r_crb[7]) d = d ^ 8'h80;
                        end
                        if (r_crb[7]) n_alm[addr[1:0]] = d;
                        else begin
                            if (addr == ADDR_TOD10) n_halt = 1'b0;
                            if (addr == ADDR_TODH) n_halt = 1'b1;
                            n_tod[addr[1:0]] = d;
                        end
                        alarm_eq = (n_alm[0] == n_tod[0]) && (n_alm[1] == n_tod[1]) &&
                                   (n_alm[2] == n_tod[2]) && (n_alm[3] == n_tod[3]);
                        if (!n_halt && alarm_eq) begin
                            n_ist = r_ist | INT_ALARM;
                            if ((n_ist[4:0] & r_imsk) != 5'd0) n_ist = n_ist | INT_REQ;
                        end
                    end
                    ADDR_ICR: begin
                        if (wd[7]) n_imsk = r_imsk | wd[4:0];
                        else n_imsk = r_imsk & ~wd[4:0];
                        if (r_ist != 8'd0 && (r_ist[4:0] & n_imsk) != 5'd0)
                            n_ist = r_ist | INT_REQ;
                    end
                    ADDR_CRA: begin
                        n_cra = wd & 8'hef;
                        if (wd[4] || ((wd & 8'h21) != 8'h01)) n_ta = r_tal;
                    end
                    ADDR_CRB: begin
                        n_crb = wd & 8'hef;
                        if (wd[4] || ((wd & 8'h61) != 8'h01)) n_tb = r_tbl;
                    end
                    default: ;
                endcase
            end
            default: begin
                div_p = r_div + 3'd1;
                n_div = div_p;
                if (div_p >= (r_cra[7] ? 3'd5 : 3'd6)) begin
                    n_div = 3'd0;
                    if (!r_halt) begin
                        n_tod[0] = bcd_inc_tenths(r_tod[0], c0);
                        if (c0) begin
                            n_tod[1] = bcd_inc_sixty(r_tod[1], c1);
                            if (c1) begin
                                n_tod[2] = bcd_inc_sixty(r_tod[2], c2);
                                if (c2) begin
                                    h = r_tod[3][4:0];
                                    hpm = {r_tod[3][7] ^ (h == 5'h11), 7'd0};
                                    if (h == 5'h12) h = 5'd1;
                                    else begin
                                        h = h + 5'd1;
                                        if (h == 5'd10) h = 5'h10;
                                    end
                                    n_tod[3] = hpm | {3'd0, h};
                                end
                            end
                        end
                        alarm_eq = (r_alm[0] == n_tod[0]) && (r_alm[1] == n_tod[1]) &&
                                   (r_alm[2] == n_tod[2]) && (r_alm[3] == n_tod[3]);
                        if (alarm_eq) begin
                            n_ist = r_ist | INT_ALARM;
                            if ((n_ist[4:0] & r_imsk) != 5'd0) n_ist = n_ist | INT_REQ;
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ta <= 16'hffff; r_tal <= 16'hffff; r_tb <= 16'hffff; r_tbl <= 16'hffff;
            r_cra <= 8'h00; r_crb <= 8'h00; r_imsk <= 5'd0; r_ist <= 8'h00;
            r_rot <= 8'hf0; r_held <= 1'b0; r_halt <= 1'b1; r_div <= 3'd0;
            r_ov <= 1'b0; r_rd <= 8'h00; r_irq <= 1'b0;
            for (int i = 0; i < 16; i++) r_sh[i] <= 8'h00;
            for (int i = 0; i < 4; i++) begin
                r_tod[i] <= (i == 3) ? 8'h01 : 8'h00;
                r_alm[i] <= 8'h00; r_hold[i] <= 8'h00;
            end
        end else begin
            if (o_rsp.ready) r_ov <= 1'b0;
            if (acc) begin
                r_ta <= n_ta; r_tal <= n_tal; r_tb <= n_tb; r_tbl <= n_tbl;
                r_cra <= n_cra; r_crb <= n_crb; r_imsk <= n_imsk; r_ist <= n_ist;
                r_rot <= n_rot; r_held <= n_held; r_halt <= n_halt; r_div <= n_div;
                r_tod <= n_tod; r_alm <= n_alm; r_hold <= n_hold;
                if (req == REQ_WRITE) r_sh[addr] <= wd;
                r_ov <= 1'b1; r_rd <= n_rd; r_irq <= n_ist[7];
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_irq_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> (r_irq == r_ist[7])) else $error("irq not equal to status bit 7");
    a_icr_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && req == REQ_READ && addr == ADDR_ICR) |=> (r_ist == 8'h00))
        else $error("interrupt status not cleared on read");
    a_div_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div <= 3'd5) else $error("mains divider out of range");
    a_no_force_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_cra[4] && !r_crb[4]) else $error("force load bit stored");
`endif
endmodule
